// ===== src/melody_note_sequencer_defines.svh =====
// ----------------------------------------------------------------------------
// Melody note sequencer assertion macros
// Shorthand for the concurrent checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef MELODY_NOTE_SEQUENCER_DEFINES_SVH
`define MELODY_NOTE_SEQUENCER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MSQ_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define MSQ_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== src/msq_pkg.sv =====
// ----------------------------------------------------------------------------
// Melody note sequencer package
// Shared types, codes and constants of the sequencer front, back and queues.
// ----------------------------------------------------------------------------
package msq_pkg;

   // Default configuration of the song store and the inter-note gap.
   localparam int SONGS_DEF     = 8;
   localparam int MAX_NOTES_DEF = 256;
   localparam int GAP_MS_DEF    = 15;

   // Depths of the command queue and the result queue.
   localparam int CMD_DEPTH = 4;
   localparam int RSP_DEPTH = 4;

   // Request codes as they arrive on the input channel.
   localparam logic [3:0] REQ_TICK      = 4'd0;
   localparam logic [3:0] REQ_PLAY      = 4'd1;
   localparam logic [3:0] REQ_PAUSE     = 4'd2;
   localparam logic [3:0] REQ_RESUME    = 4'd3;
   localparam logic [3:0] REQ_STOP      = 4'd4;
   localparam logic [3:0] REQ_NEXT      = 4'd5;
   localparam logic [3:0] REQ_PREV      = 4'd6;
   localparam logic [3:0] REQ_LOAD_NOTE = 4'd7;
   localparam logic [3:0] REQ_LOAD_LEN  = 4'd8;

   // Decoded operations handed from the front to the back.
   typedef enum logic [3:0] {
      OP_TICK,
      OP_PLAY,
      OP_PAUSE,
      OP_RESUME,
      OP_STOP,
      OP_NEXT,
      OP_PREV,
      OP_LOAD_NOTE,
      OP_LOAD_LEN,
      OP_NONE
   } msq_op_type;

   // Player mode, also driven on the result channel.
   typedef enum logic [1:0] {
      MODE_STOPPED = 2'd0,
      MODE_PLAYING = 2'd1,
      MODE_PAUSED  = 2'd2
   } msq_mode_type;

   // One input item.
   typedef struct packed {
      logic [3:0]  req_type;
      logic [7:0]  song_sel;
      logic [7:0]  note_sel;
      logic [15:0] load_freq;
      logic [15:0] load_ms;
      logic [8:0]  load_count;
   } msq_req_type;

   // One result item.
   typedef struct packed {
      logic [15:0] tone_freq;
      logic [1:0]  player_mode;
      logic [7:0]  song_now;
      logic [7:0]  note_now;
      logic        song_ended;
   } msq_rsp_type;

   // A classified item waiting in the command queue.
   typedef struct packed {
      msq_op_type  op;
      logic        song_ok;
      logic        note_ok;
      logic [7:0]  song;
      logic [7:0]  note;
      logic [15:0] freq;
      logic [15:0] dur_ms;
      logic [8:0]  count;
   } msq_cmd_type;

   // Free space of the result queue as seen by the back.
   typedef struct packed {
      logic has_one;
      logic has_two;
   } msq_room_type;

   // One entry of the note store.
   typedef struct packed {
      logic [15:0] freq;
      logic [15:0] dur_ms;
   } msq_note_type;

endpackage

// ===== src/msq_front.sv =====
// ----------------------------------------------------------------------------
// Melody note sequencer front
// Accepts input items, decodes and range-checks them, and queues the
// classified commands for the back.
// ----------------------------------------------------------------------------
module msq_front import msq_pkg::*; #(
   parameter int SONGS     = SONGS_DEF,
   parameter int MAX_NOTES = MAX_NOTES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   output logic        full,
   input  msq_req_type req_item,
   output logic        cmd_valid,
   output msq_cmd_type cmd_item,
   input  logic        cmd_pop
);

   localparam int PTR_W = (CMD_DEPTH > 1) ? $clog2(CMD_DEPTH) : 1;
   localparam int CNT_W = $clog2(CMD_DEPTH + 1);

   msq_cmd_type             queue_ff [CMD_DEPTH];
   logic [PTR_W-1:0]        wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]        rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]        count_ff, count_in;
   msq_cmd_type             decoded;
   logic                    do_push;
   logic                    do_pop;

   // Decode the request code and check the song and note ranges.
   always_comb begin
      decoded.song_ok = ({1'b0, req_item.song_sel} < 9'(SONGS));
      decoded.note_ok = ({1'b0, req_item.note_sel} < 9'(MAX_NOTES));
      decoded.song    = req_item.song_sel;
      decoded.note    = req_item.note_sel;
      decoded.freq    = req_item.load_freq;
      decoded.dur_ms  = req_item.load_ms;
      decoded.count   = req_item.load_count;
      case (req_item.req_type)
         REQ_TICK:      decoded.op = OP_TICK;
         REQ_PLAY:      decoded.op = OP_PLAY;
         REQ_PAUSE:     decoded.op = OP_PAUSE;
         REQ_RESUME:    decoded.op = OP_RESUME;
         REQ_STOP:      decoded.op = OP_STOP;
         REQ_NEXT:      decoded.op = OP_NEXT;
         REQ_PREV:      decoded.op = OP_PREV;
         REQ_LOAD_NOTE: decoded.op = OP_LOAD_NOTE;
         REQ_LOAD_LEN:  decoded.op = OP_LOAD_LEN;
         default:       decoded.op = OP_NONE;
      endcase
   end

   // Queue handshake on both sides.
   assign full      = (count_ff == CNT_W'(CMD_DEPTH));
   assign cmd_valid = (count_ff != '0);
   assign cmd_item  = queue_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = cmd_pop && cmd_valid;

   // Pointer and fill count updates, wrapping at the queue depth.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(CMD_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(CMD_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   // Queue control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Queue storage; the payload needs no reset.
   always_ff @(posedge clock) begin
      if (do_push) begin
         queue_ff[wr_ptr_ff] <= decoded;
      end
   end

endmodule

// ===== src/msq_back.sv =====
// ----------------------------------------------------------------------------
// Melody note sequencer back
// Carries out one queued command a cycle while the result queue has room:
// player state, note and length stores, and the registered result for it.
// ----------------------------------------------------------------------------
module msq_back import msq_pkg::*; #(
   parameter int SONGS     = SONGS_DEF,
   parameter int MAX_NOTES = MAX_NOTES_DEF,
   parameter int GAP_MS    = GAP_MS_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         cmd_valid,
   input  msq_cmd_type  cmd_item,
   output logic         cmd_pop,
   input  msq_room_type rsp_room,
   output logic         rsp_push,
   output msq_rsp_type  rsp_item
);

   localparam int SONG_W     = (SONGS > 1) ? $clog2(SONGS) : 1;
   localparam int NOTE_DEPTH = SONGS * MAX_NOTES;
   localparam int ADDR_W     = (NOTE_DEPTH > 1) ? $clog2(NOTE_DEPTH) : 1;

   // Note store and song length store.
   msq_note_type      note_mem [NOTE_DEPTH];
   logic [8:0]        len_mem  [SONGS];
   msq_note_type      note_rd_ff;
   logic [8:0]        len_rd_ff;

   // Player state.
   msq_mode_type      mode_ff, mode_in;
   logic [SONG_W-1:0] song_ff, song_in;
   logic [7:0]        note_ff, note_in;
   logic [15:0]       rem_ff, rem_in;
   logic [3:0]        gap_ff, gap_in;
   logic [15:0]       tone_ff, tone_in;
   logic              pend_ff;
   logic [8:0]        len_ff, len_in;
   logic              len_pend_ff;

   // Registered result.
   logic              res_valid_ff;
   logic              res_mem_ff;
   logic [15:0]       res_tone_ff;
   msq_mode_type      res_mode_ff;
   logic [7:0]        res_song_ff;
   logic [7:0]        res_note_ff;
   logic              res_ended_ff;

   // Command decode results.
   logic              fire;
   logic              start;
   logic              ended;
   logic              note_we;
   logic              len_we;
   logic              len_re;
   logic [SONG_W-1:0] cmd_song;
   logic [SONG_W-1:0] next_song;
   logic [SONG_W-1:0] prev_song;
   logic [15:0]       cur_tone;
   logic [15:0]       cur_rem;
   logic [8:0]        cur_len;
   logic [8:0]        used_len;
   logic [8:0]        note_next;
   logic [ADDR_W-1:0] rd_addr;
   logic [ADDR_W-1:0] wr_addr;

   // A started note takes its tone and duration from the store read; in the
   // cycle after the start, the read data stands in for the registers.
   assign cur_tone = pend_ff ? note_rd_ff.freq : tone_ff;
   assign cur_rem  = pend_ff ? note_rd_ff.dur_ms : rem_ff;
   assign cur_len  = len_pend_ff ? len_rd_ff : len_ff;
   assign used_len = (cur_len > 9'(MAX_NOTES)) ? 9'(MAX_NOTES) : cur_len;

   assign note_next = {1'b0, note_ff} + 9'd1;
   assign cmd_song  = cmd_item.song[SONG_W-1:0];
   assign next_song = (song_ff == SONG_W'(SONGS - 1)) ? '0 : song_ff + 1'b1;
   assign prev_song = (song_ff == '0) ? SONG_W'(SONGS - 1) : song_ff - 1'b1;

   // A command runs when the result queue has room for it and for the
   // result still in the output register.
   assign fire    = cmd_valid && (res_valid_ff ? rsp_room.has_two : rsp_room.has_one);
   assign cmd_pop = fire;

   // Next-state logic of the player.
   always_comb begin
      mode_in  = mode_ff;
      song_in  = song_ff;
      note_in  = note_ff;
      rem_in   = cur_rem;
      gap_in   = gap_ff;
      tone_in  = cur_tone;
      len_in   = cur_len;
      start    = 1'b0;
      ended    = 1'b0;
      note_we  = 1'b0;
      len_we   = 1'b0;
      len_re   = 1'b0;
      if (fire) begin
         case (cmd_item.op)
            OP_TICK: begin
               if (mode_ff == MODE_PLAYING) begin
                  if (gap_ff != '0) begin
                     gap_in = gap_ff - 1'b1;
                     start  = (gap_ff == 4'd1);
                  end else if (cur_rem > 16'd1) begin
                     rem_in = cur_rem - 1'b1;
                  end else begin
                     // The note has expired: go silent and move on.
                     tone_in = '0;
                     rem_in  = '0;
                     if (note_next >= used_len) begin
                        mode_in = MODE_STOPPED;
                        note_in = '0;
                        ended   = 1'b1;
                     end else begin
                        note_in = note_next[7:0];
                        if (GAP_MS == 0) begin
                           start = 1'b1;
                        end else begin
                           gap_in = 4'(GAP_MS);
                        end
                     end
                  end
               end
            end
            OP_PLAY: begin
               if (cmd_item.song_ok) begin
                  song_in = cmd_song;
                  note_in = '0;
                  mode_in = MODE_PLAYING;
                  start   = 1'b1;
                  len_re  = 1'b1;
               end
            end
            OP_PAUSE: begin
               if (mode_ff == MODE_PLAYING) begin
                  tone_in = '0;
                  gap_in  = '0;
                  mode_in = MODE_PAUSED;
               end
            end
            OP_RESUME: begin
               if (mode_ff == MODE_PAUSED) begin
                  mode_in = MODE_PLAYING;
                  start   = 1'b1;
               end
            end
            OP_STOP: begin
               tone_in = '0;
               mode_in = MODE_STOPPED;
               note_in = '0;
               gap_in  = '0;
               rem_in  = '0;
            end
            OP_NEXT: begin
               song_in = next_song;
               note_in = '0;
               mode_in = MODE_PLAYING;
               start   = 1'b1;
               len_re  = 1'b1;
            end
            OP_PREV: begin
               song_in = prev_song;
               note_in = '0;
               mode_in = MODE_PLAYING;
               start   = 1'b1;
               len_re  = 1'b1;
            end
            OP_LOAD_NOTE: begin
               note_we = cmd_item.song_ok && cmd_item.note_ok;
            end
            OP_LOAD_LEN: begin
               if (cmd_item.song_ok) begin
                  len_we = 1'b1;
                  // Keep the cached length of the current song up to date.
                  if (cmd_song == song_ff) begin
                     len_in = cmd_item.count;
                  end
               end
            end
            default: begin
            end
         endcase
         // Starting a note always clears the gap.
         if (start) begin
            gap_in = '0;
         end
      end
   end

   // Store addresses: the note to start and the note to load.
   assign rd_addr = ADDR_W'(song_in) * ADDR_W'(MAX_NOTES) + ADDR_W'(note_in);
   assign wr_addr = ADDR_W'(cmd_song) * ADDR_W'(MAX_NOTES) + ADDR_W'(cmd_item.note);

   // Note store: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (note_we) begin
         note_mem[wr_addr] <= {cmd_item.freq, cmd_item.dur_ms};
      end
      if (start) begin
         note_rd_ff <= note_mem[rd_addr];
      end
   end

   // Song length store: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (len_we) begin
         len_mem[cmd_song] <= cmd_item.count;
      end
      if (len_re) begin
         len_rd_ff <= len_mem[song_in];
      end
   end

   // Player state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff     <= MODE_STOPPED;
         song_ff     <= '0;
         note_ff     <= '0;
         rem_ff      <= '0;
         gap_ff      <= '0;
         tone_ff     <= '0;
         pend_ff     <= 1'b0;
         len_pend_ff <= 1'b0;
         len_ff      <= '0;
      end else begin
         mode_ff     <= mode_in;
         song_ff     <= song_in;
         note_ff     <= note_in;
         rem_ff      <= rem_in;
         gap_ff      <= gap_in;
         tone_ff     <= tone_in;
         pend_ff     <= start;
         len_pend_ff <= len_re;
         len_ff      <= len_in;
      end
   end

   // Result register; the tone of a started note is filled in from the
   // store read when the result moves on.
   always_ff @(posedge clock) begin
      if (reset) begin
         res_valid_ff <= 1'b0;
      end else begin
         res_valid_ff <= fire;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         res_mem_ff   <= start;
         res_tone_ff  <= tone_in;
         res_mode_ff  <= mode_in;
         res_song_ff  <= 8'(song_in);
         res_note_ff  <= note_in;
         res_ended_ff <= ended;
      end
   end

   // Result toward the result queue.
   assign rsp_push             = res_valid_ff;
   assign rsp_item.tone_freq   = res_mem_ff ? note_rd_ff.freq : res_tone_ff;
   assign rsp_item.player_mode = res_mode_ff;
   assign rsp_item.song_now    = res_song_ff;
   assign rsp_item.note_now    = res_note_ff;
   assign rsp_item.song_ended  = res_ended_ff;

endmodule

// ===== src/msq_rsp_queue.sv =====
// ----------------------------------------------------------------------------
// Melody note sequencer result queue
// Holds finished results until the receiver pops them, and reports its
// free space to the back.
// ----------------------------------------------------------------------------
module msq_rsp_queue import msq_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         rsp_push,
   input  msq_rsp_type  rsp_in,
   output msq_room_type rsp_room,
   output logic         empty,
   input  logic         pop,
   output msq_rsp_type  rsp_item
);

   localparam int PTR_W = (RSP_DEPTH > 1) ? $clog2(RSP_DEPTH) : 1;
   localparam int CNT_W = $clog2(RSP_DEPTH + 1);

   msq_rsp_type      queue_ff [RSP_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_pop;

   // Status toward both sides.
   assign empty            = (count_ff == '0);
   assign rsp_item         = queue_ff[rd_ptr_ff];
   assign do_pop           = pop && !empty;
   assign rsp_room.has_one = (count_ff < CNT_W'(RSP_DEPTH));
   assign rsp_room.has_two = ({1'b0, count_ff} + 1'b1 < (CNT_W + 1)'(RSP_DEPTH));

   // Pointer and fill count updates.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (rsp_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(RSP_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(RSP_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (rsp_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !rsp_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   // Queue control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Queue storage; the back only pushes when there is room.
   always_ff @(posedge clock) begin
      if (rsp_push) begin
         queue_ff[wr_ptr_ff] <= rsp_in;
      end
   end

endmodule

// ===== src/melody_note_sequencer.sv =====
// ----------------------------------------------------------------------------
// Melody note sequencer
// Buzzer melody player with loadable songs, driven by 1 ms ticks and
// transport commands, one result item for every input item.
// ----------------------------------------------------------------------------
// Usage:
// Input items enter as a queue: an item is taken on a clock edge with push
// high and full low. Each item is a tick, a transport command (play, pause,
// resume, stop, next, prev) or a load of a note or a song length.
// Every item yields one result item with the tone, mode, song and note.
// Results leave as a queue: the oldest one is shown while empty is low and
// is taken on a clock edge with pop high.
// Accepted items pass the command queue, result register and result queue.
// Throughput is one item per cycle; the back runs one command a cycle and
// a note start is completed by the registered read of the note store.
// When the receiver stalls, the result queue and then the command queue fill
// and full rises; nothing is lost.
// Reset is synchronous: the player is stopped on song 0, note 0, silent, and
// both queues are empty. Song and note stores keep no reset value and must
// be loaded before they are played.
// ----------------------------------------------------------------------------
`include "melody_note_sequencer_defines.svh"

module melody_note_sequencer import msq_pkg::*; #(
   parameter int SONGS     = SONGS_DEF,
   parameter int MAX_NOTES = MAX_NOTES_DEF,
   parameter int GAP_MS    = GAP_MS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   output logic        full,
   input  msq_req_type req_item,
   output logic        empty,
   input  logic        pop,
   output msq_rsp_type rsp_item
);

   logic         cmd_valid;
   msq_cmd_type  cmd_item;
   logic         cmd_pop;
   msq_room_type rsp_room;
   logic         rsp_push;
   msq_rsp_type  rsp_in;

   // Front: decode and queue the input items.
   msq_front #(
      .SONGS     (SONGS),
      .MAX_NOTES (MAX_NOTES)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .full      (full),
      .req_item  (req_item),
      .cmd_valid (cmd_valid),
      .cmd_item  (cmd_item),
      .cmd_pop   (cmd_pop)
   );

   // Back: run the player and the song stores.
   msq_back #(
      .SONGS     (SONGS),
      .MAX_NOTES (MAX_NOTES),
      .GAP_MS    (GAP_MS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd_item  (cmd_item),
      .cmd_pop   (cmd_pop),
      .rsp_room  (rsp_room),
      .rsp_push  (rsp_push),
      .rsp_item  (rsp_in)
   );

   // Result queue toward the receiver.
   msq_rsp_queue u_rsp_queue (
      .clock    (clock),
      .reset    (reset),
      .rsp_push (rsp_push),
      .rsp_in   (rsp_in),
      .rsp_room (rsp_room),
      .empty    (empty),
      .pop      (pop),
      .rsp_item (rsp_item)
   );

   // The back never pushes a result into a full result queue.
   `MSQ_ASSERT_NOW(a_rsp_no_overflow, rsp_push, rsp_room.has_one, "result queue overflow")

   // An accepted item is waiting for the back on the next cycle.
   `MSQ_ASSERT_NEXT(a_cmd_queued, push && !full, cmd_valid, "accepted item not queued")

   // The buzzer is silent whenever the player is not playing.
   `MSQ_ASSERT_NOW(a_silent_idle, !empty && (rsp_item.player_mode != MODE_PLAYING), rsp_item.tone_freq == 16'd0, "tone while not playing")

   // A song that has just ended leaves the player stopped.
   `MSQ_ASSERT_NOW(a_end_stops, !empty && rsp_item.song_ended, rsp_item.player_mode == MODE_STOPPED, "song ended while not stopped")

endmodule

// ===== tb/msq_status_checker.sv =====
// ----------------------------------------------------------------------------
// Melody note sequencer status checker
// Watches both queue sides of the sequencer and keeps its own player model.
// Each accepted item adds one predicted status, and each popped result is
// compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module msq_status_checker import msq_pkg::*; #(
   parameter int SONGS     = SONGS_DEF,
   parameter int MAX_NOTES = MAX_NOTES_DEF,
   parameter int GAP_MS    = GAP_MS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   input  logic        full,
   input  msq_req_type req_item,
   input  logic        empty,
   input  logic        pop,
   input  msq_rsp_type rsp_item,
   output int          mismatch_count,
   output int          waiting_count
);

   // Player state as the sequencer should hold it.
   msq_mode_type mode_now;
   logic [7:0]   song_now;
   int           note_now;
   logic [15:0]  ms_left;
   int           gap_left;
   logic [15:0]  tone_now;

   // Song and note tables, filled only by load items.
   logic [15:0] freq_tab [SONGS*MAX_NOTES];
   logic [15:0] ms_tab   [SONGS*MAX_NOTES];
   logic [8:0]  len_tab  [SONGS];

   msq_rsp_type expected_status_q [$];
   int          errors;

   // Print one mismatch line and count it.
   task automatic report_mismatch(input string what, input longint got, input longint want);
      errors++;
      $display("mismatch at %0t: %s is %0d, expected %0d", $time, what, got, want);
   endtask

   // Number of notes that the current song actually plays.
   function automatic int used_length();
      int n;
      n = len_tab[song_now];
      if (n > MAX_NOTES) n = MAX_NOTES;
      return n;
   endfunction

   // Load the current note from the tables and cancel any gap.
   function automatic void start_note();
      int idx;
      idx      = int'(song_now) * MAX_NOTES + note_now;
      tone_now = freq_tab[idx];
      ms_left  = ms_tab[idx];
      gap_left = 0;
   endfunction

   function automatic void play_song(input int song);
      song_now = 8'(song);
      note_now = 0;
      mode_now = MODE_PLAYING;
      start_note();
   endfunction

   // Apply one item to the player state and return the status it shows.
   function automatic msq_rsp_type predict_status(input msq_req_type rq);
      msq_rsp_type st;
      logic        ended;
      ended = 1'b0;
      case (rq.req_type)
         REQ_TICK: begin
            if (mode_now == MODE_PLAYING) begin
               if (gap_left > 0) begin
                  gap_left--;
                  if (gap_left == 0) start_note();
               end else if (ms_left > 1) begin
                  ms_left--;
               end else begin
                  // The note has run out: go silent and move to the next one.
                  tone_now = '0;
                  ms_left  = '0;
                  note_now++;
                  if (note_now >= used_length()) begin
                     mode_now = MODE_STOPPED;
                     note_now = 0;
                     ended    = 1'b1;
                  end else if (GAP_MS == 0) begin
                     start_note();
                  end else begin
                     gap_left = GAP_MS;
                  end
               end
            end
         end
         REQ_PLAY: begin
            if (rq.song_sel < SONGS) play_song(rq.song_sel);
         end
         REQ_PAUSE: begin
            if (mode_now == MODE_PLAYING) begin
               tone_now = '0;
               gap_left = 0;
               mode_now = MODE_PAUSED;
            end
         end
         REQ_RESUME: begin
            if (mode_now == MODE_PAUSED) begin
               mode_now = MODE_PLAYING;
               start_note();
            end
         end
         REQ_STOP: begin
            tone_now = '0;
            mode_now = MODE_STOPPED;
            note_now = 0;
            gap_left = 0;
            ms_left  = '0;
         end
         REQ_NEXT: play_song((int'(song_now) + 1) % SONGS);
         REQ_PREV: play_song(song_now == 0 ? SONGS - 1 : int'(song_now) - 1);
         REQ_LOAD_NOTE: begin
            if (rq.song_sel < SONGS && rq.note_sel < MAX_NOTES) begin
               freq_tab[int'(rq.song_sel) * MAX_NOTES + rq.note_sel] = rq.load_freq;
               ms_tab[int'(rq.song_sel) * MAX_NOTES + rq.note_sel]   = rq.load_ms;
            end
         end
         REQ_LOAD_LEN: begin
            if (rq.song_sel < SONGS) len_tab[rq.song_sel] = rq.load_count;
         end
         default: ;
      endcase
      st.tone_freq   = tone_now;
      st.player_mode = mode_now;
      st.song_now    = song_now;
      st.note_now    = 8'(note_now);
      st.song_ended  = ended;
      return st;
   endfunction

   // Predict on every accepted item, compare on every popped result.
   always @(posedge clock) begin
      msq_rsp_type want;
      if (reset) begin
         mode_now = MODE_STOPPED;
         song_now = '0;
         note_now = 0;
         ms_left  = '0;
         gap_left = 0;
         tone_now = '0;
         errors   = 0;
         expected_status_q.delete();
      end else begin
         if (push && !full) expected_status_q.push_back(predict_status(req_item));
         if (pop && !empty) begin
            if (expected_status_q.size() == 0) begin
               report_mismatch("result with no item waiting", rsp_item, 0);
            end else begin
               want = expected_status_q.pop_front();
               if (rsp_item.tone_freq !== want.tone_freq)
                  report_mismatch("tone_freq", rsp_item.tone_freq, want.tone_freq);
               if (rsp_item.player_mode !== want.player_mode)
                  report_mismatch("player_mode", rsp_item.player_mode, want.player_mode);
               if (rsp_item.song_now !== want.song_now)
                  report_mismatch("song_now", rsp_item.song_now, want.song_now);
               if (rsp_item.note_now !== want.note_now)
                  report_mismatch("note_now", rsp_item.note_now, want.note_now);
               if (rsp_item.song_ended !== want.song_ended)
                  report_mismatch("song_ended", rsp_item.song_ended, want.song_ended);
            end
         end
      end
      mismatch_count <= errors;
      waiting_count  <= expected_status_q.size();
   end

endmodule

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// Melody note sequencer testbench
// Loads every song, runs a short directed pass over the transport commands
// and load cases, then three random phases with different idling on both
// queue sides, including a long receiver hold that fills the block.
// The status checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module testbench;
   import msq_pkg::*;

   localparam int          RANDOM_ITEMS   = 240;
   localparam int          CYCLE_LIMIT    = 200000;
   localparam int          HOLD_CYCLES    = 60;
   localparam int          TAIL_CYCLES    = 12;
   localparam logic [3:0]  REQ_UNUSED_TOP = 4'hF;

   logic        clock;
   logic        reset;
   logic        push;
   logic        full;
   msq_req_type req_item;
   logic        empty;
   logic        pop;
   msq_rsp_type rsp_item;
   int          mismatch_count;
   int          waiting_count;

   // Idling of both sides, set per phase by the stimulus.
   int phase;
   int send_idle_pct;
   int recv_idle_pct;

   // Which notes have been written, so no unwritten note is ever played.
   bit note_loaded [SONGS_DEF][MAX_NOTES_DEF];
   int loaded_prefix [SONGS_DEF];

   melody_note_sequencer dut (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .full     (full),
      .req_item (req_item),
      .empty    (empty),
      .pop      (pop),
      .rsp_item (rsp_item)
   );

   msq_status_checker status_check (
      .clock          (clock),
      .reset          (reset),
      .push           (push),
      .full           (full),
      .req_item       (req_item),
      .empty          (empty),
      .pop            (pop),
      .rsp_item       (rsp_item),
      .mismatch_count (mismatch_count),
      .waiting_count  (waiting_count)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Record a note write and extend the run of written notes from note 0.
   function automatic void mark_note(input int song, input int note);
      if (song < SONGS_DEF && note < MAX_NOTES_DEF) begin
         note_loaded[song][note] = 1'b1;
         while (loaded_prefix[song] < MAX_NOTES_DEF && note_loaded[song][loaded_prefix[song]])
            loaded_prefix[song]++;
      end
   endfunction

   // Mostly short notes, now and then a long or arbitrary one.
   function automatic logic [15:0] note_length();
      int r;
      r = $urandom_range(99);
      if (r < 80) return 16'($urandom_range(8));
      if (r < 95) return 16'($urandom_range(60));
      return 16'($urandom);
   endfunction

   function automatic msq_req_type make_request(input logic [3:0] kind, input int song,
                                                input int note, input int freq, input int ms,
                                                input int count);
      msq_req_type rq;
      rq.req_type   = kind;
      rq.song_sel   = 8'(song);
      rq.note_sel   = 8'(note);
      rq.load_freq  = 16'(freq);
      rq.load_ms    = 16'(ms);
      rq.load_count = 9'(count);
      if (kind == REQ_LOAD_NOTE) mark_note(song, note);
      return rq;
   endfunction

   // Random item: mostly ticks, with commands and loads mixed in.
   function automatic msq_req_type random_request();
      msq_req_type rq;
      int          pick;
      rq.req_type   = REQ_TICK;
      rq.song_sel   = 8'($urandom);
      rq.note_sel   = 8'($urandom);
      rq.load_freq  = 16'($urandom);
      rq.load_ms    = 16'($urandom);
      rq.load_count = 9'($urandom_range(1, MAX_NOTES_DEF));
      pick = $urandom_range(99);
      if (pick < 55 || (pick >= 92 && pick < 97)) begin
         rq.req_type = REQ_TICK;
      end else if (pick < 60) begin
         rq.req_type = REQ_PLAY;
         if ($urandom_range(4) != 0) rq.song_sel = 8'($urandom_range(SONGS_DEF - 1));
      end else if (pick < 63) begin
         rq.req_type = REQ_PAUSE;
      end else if (pick < 66) begin
         rq.req_type = REQ_RESUME;
      end else if (pick < 68) begin
         rq.req_type = REQ_STOP;
      end else if (pick < 71) begin
         rq.req_type = REQ_NEXT;
      end else if (pick < 74) begin
         rq.req_type = REQ_PREV;
      end else if (pick < 85) begin
         rq.req_type = REQ_LOAD_NOTE;
         if ($urandom_range(6) != 0) rq.song_sel = 8'($urandom_range(SONGS_DEF - 1));
         // Half the in-range loads extend the written run of the song.
         if (rq.song_sel < SONGS_DEF && loaded_prefix[rq.song_sel] < MAX_NOTES_DEF &&
             $urandom_range(1) == 1)
            rq.note_sel = 8'(loaded_prefix[rq.song_sel]);
         rq.load_freq = ($urandom_range(9) == 0) ? 16'd0 : 16'($urandom);
         rq.load_ms   = note_length();
         mark_note(rq.song_sel, rq.note_sel);
      end else if (pick < 92) begin
         rq.req_type = REQ_LOAD_LEN;
         if ($urandom_range(6) != 0) rq.song_sel = 8'($urandom_range(SONGS_DEF - 1));
         if (rq.song_sel < SONGS_DEF)
            rq.load_count = 9'($urandom_range(1, loaded_prefix[rq.song_sel]));
      end else begin
         rq.req_type = 4'($urandom_range(int'(REQ_LOAD_LEN) + 1, int'(REQ_UNUSED_TOP)));
      end
      return rq;
   endfunction

   // Offer one item after a random gap and hold it until it is taken.
   task automatic send_item(input msq_req_type item);
      while ($urandom_range(99) < send_idle_pct) begin
         push <= 1'b0;
         @(posedge clock);
      end
      push     <= 1'b1;
      req_item <= item;
      do @(posedge clock); while (full);
   endtask

   // Result side: random pops, with one long hold at the start of each later phase.
   initial begin : receiver
      int held_phase;
      held_phase = 0;
      pop = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (phase != held_phase) begin
            held_phase = phase;
            pop <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else begin
            pop <= ($urandom_range(99) >= recv_idle_pct);
            @(posedge clock);
         end
      end
   end

   // Runaway guard.
   initial begin : watchdog
      int unsigned cycles;
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("CHECK FAILED");
      $finish;
   end

   initial begin : stimulus
      int song;
      int note;
      int len;
      int ms;
      reset         = 1'b1;
      push          = 1'b0;
      req_item      = '0;
      phase         = 0;
      send_idle_pct = 33;
      recv_idle_pct = 81;
      foreach (loaded_prefix[i]) loaded_prefix[i] = 0;
      foreach (note_loaded[i, j]) note_loaded[i][j] = 1'b0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Load every song before anything is played. Song 1 is a single short
      // note so that it ends on its first tick; the last song is full length.
      for (song = 0; song < SONGS_DEF; song++) begin
         if (song == SONGS_DEF - 1) len = MAX_NOTES_DEF;
         else if (song == 1) len = 1;
         else len = $urandom_range(1, 6);
         for (note = 0; note < len; note++) begin
            if (song == 1) ms = 0;
            else if (song == SONGS_DEF - 1) ms = $urandom_range(2);
            else ms = note_length();
            send_item(make_request(REQ_LOAD_NOTE, song, note,
                                   ($urandom_range(9) == 0) ? 0 : $urandom_range(65535), ms, 0));
         end
         send_item(make_request(REQ_LOAD_LEN, song, 0, 0, 0, len));
      end

      // Directed pass over the commands and the corner cases.
      send_item(make_request(REQ_TICK, 0, 0, 0, 0, 0));
      send_item(make_request(REQ_PLAY, 255, 0, 0, 0, 0));
      send_item(make_request(REQ_PLAY, 1, 0, 0, 0, 0));
      send_item(make_request(REQ_TICK, 0, 0, 0, 0, 0));
      send_item(make_request(REQ_PLAY, 0, 0, 0, 0, 0));
      send_item(make_request(REQ_TICK, 0, 0, 0, 0, 0));
      send_item(make_request(REQ_PAUSE, 0, 0, 0, 0, 0));
      send_item(make_request(REQ_TICK, 0, 0, 0, 0, 0));
      send_item(make_request(REQ_PAUSE, 0, 0, 0, 0, 0));
      send_item(make_request(REQ_RESUME, 0, 0, 0, 0, 0));
      send_item(make_request(REQ_TICK, 0, 0, 0, 0, 0));
      send_item(make_request(REQ_STOP, 0, 0, 0, 0, 0));
      send_item(make_request(REQ_RESUME, 0, 0, 0, 0, 0));
      send_item(make_request(REQ_PAUSE, 0, 0, 0, 0, 0));
      send_item(make_request(REQ_PREV, 0, 0, 0, 0, 0));
      send_item(make_request(REQ_NEXT, 0, 0, 0, 0, 0));
      send_item(make_request(REQ_LOAD_NOTE, SONGS_DEF, 0, 65535, 65535, 0));
      send_item(make_request(REQ_LOAD_NOTE, SONGS_DEF - 1, MAX_NOTES_DEF - 1, 65535, 65535, 0));
      send_item(make_request(REQ_LOAD_NOTE, 2, MAX_NOTES_DEF - 1, 0, 0, 0));
      send_item(make_request(REQ_LOAD_LEN, 255, 0, 0, 0, MAX_NOTES_DEF));
      send_item(make_request(REQ_LOAD_LEN, SONGS_DEF - 1, 0, 0, 0, MAX_NOTES_DEF));
      send_item(make_request(REQ_UNUSED_TOP, 255, 255, 65535, 65535, 511));
      send_item(make_request(REQ_PLAY, SONGS_DEF - 1, 0, 0, 0, 0));
      send_item(make_request(REQ_TICK, 0, 0, 0, 0, 0));
      send_item(make_request(REQ_STOP, 0, 0, 0, 0, 0));

      // Random phases: slow receiver, then slow sender, then no idling.
      for (int p = 0; p < 3; p++) begin
         phase         = p;
         send_idle_pct = (p == 0) ? 33 : (p == 1) ? 81 : 0;
         recv_idle_pct = (p == 0) ? 81 : (p == 1) ? 33 : 0;
         repeat (RANDOM_ITEMS / 3) send_item(random_request());
      end

      // Drain and give the verdict.
      push <= 1'b0;
      @(posedge clock);
      while (waiting_count != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

// ===== files.f =====
+incdir+src
src/msq_pkg.sv
src/msq_front.sv
src/msq_back.sv
src/msq_rsp_queue.sv
src/melody_note_sequencer.sv
tb/msq_status_checker.sv
tb/testbench.sv
